>>> rtl/scbc_pkg.sv
// ----------------------------------------------------------------------------
// scbc_pkg
// Shared constants, result codes and controller/datapath signal groups for
// the size class block cache.
// ----------------------------------------------------------------------------
package scbc_pkg;

  // Cache geometry
  localparam int NUM_CLASSES = 64;
  localparam int STACK_DEPTH = 16;
  localparam int CLASS_STEP  = 16;
  localparam int ADDR_BITS   = 48;

  // Field widths
  localparam int SIZE_W      = 20;
  localparam int STATUS_W    = 2;
  localparam int CLASS_IDX_W = 7;

  // Derived widths
  localparam int CLASS_BITS = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W     = $clog2(STACK_DEPTH + 1);
  localparam int STACK_WORDS = NUM_CLASSES * STACK_DEPTH;
  localparam int STACK_AW    = CLASS_BITS + DEPTH_BITS;
  localparam int MAX_SIZE    = NUM_CLASSES * CLASS_STEP;

  // Result codes
  localparam logic [STATUS_W-1:0] ST_DONE        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNCACHEABLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_FULL  = 2'd2;

  // Request modes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic                load;       // capture request, start fill lookup
    logic                push;       // write stack word, bump fill
    logic                pop;        // drop fill, read stack word
    logic                emit;       // register a result
    logic                found_sel;  // result carries popped address
    logic [STATUS_W-1:0] status;     // result code
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic uncacheable;
    logic is_put;
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

>>> rtl/scbc_ctrl.sv
// ----------------------------------------------------------------------------
// scbc_ctrl
// Request sequencer: accept, fill lookup, optional stack read, result.
// ----------------------------------------------------------------------------
module scbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  scbc_pkg::dp_stat_t stat,
  output scbc_pkg::dp_cmd_t  cmd
);
  import scbc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;

  logic [1:0] state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.status    = ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat.uncacheable) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_UNCACHEABLE;
          state_next = S_IDLE;
        end else if (stat.is_put) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (stat.full) begin
            cmd.status = ST_EMPTY_FULL;
          end else begin
            cmd.push   = 1'b1;
            cmd.status = ST_DONE;
          end
        end else if (stat.empty) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_EMPTY_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.emit      = 1'b1;
        cmd.found_sel = 1'b1;
        cmd.status    = ST_DONE;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/scbc_datapath.sv
// ----------------------------------------------------------------------------
// scbc_datapath
// Class computation, per-class fill counts and the address stack memory,
// plus the result registers.
// ----------------------------------------------------------------------------
module scbc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  scbc_pkg::dp_cmd_t                   cmd,
  output scbc_pkg::dp_stat_t                  stat,
  input  logic                                mode,
  input  logic [scbc_pkg::SIZE_W-1:0]         request_size,
  input  logic [scbc_pkg::ADDR_BITS-1:0]      block_address,
  output logic                                done,
  output logic [scbc_pkg::STATUS_W-1:0]       status,
  output logic [scbc_pkg::ADDR_BITS-1:0]      found_address,
  output logic [scbc_pkg::CLASS_IDX_W-1:0]    class_index
);
  import scbc_pkg::*;

  // Fill count memory with valid bits standing in for the reset clear
  logic [FILL_W-1:0]      fill_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] fill_valid;
  logic [FILL_W-1:0]      fill_rd;
  logic                   fill_rd_valid;

  // Address stack memory, contents undefined until pushed
  logic [ADDR_BITS-1:0]   stack_mem [STACK_WORDS];
  logic [ADDR_BITS-1:0]   stack_rd;

  // Captured request
  logic                   mode_q;
  logic                   uncache_q;
  logic [CLASS_BITS-1:0]  cls_q;
  logic [ADDR_BITS-1:0]   addr_q;

  logic [SIZE_W-1:0]      size_m1;
  logic                   in_uncache;
  logic [CLASS_BITS-1:0]  in_cls;
  logic [FILL_W-1:0]      fill_cur;
  logic [FILL_W-1:0]      fill_m1;
  logic [FILL_W-1:0]      fill_p1;
  logic [STACK_AW-1:0]    push_addr;
  logic [STACK_AW-1:0]    pop_addr;

  // Round size up to its class
  assign size_m1    = request_size - SIZE_W'(1);
  assign in_uncache = (request_size == '0) || (request_size > SIZE_W'(MAX_SIZE));
  assign in_cls     = CLASS_BITS'(size_m1 / CLASS_STEP);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q    <= mode;
      uncache_q <= in_uncache;
      cls_q     <= in_cls;
      addr_q    <= block_address;
    end
  end

  // Fill memory read on accept, registered
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fill_rd <= fill_mem[in_cls];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_valid    <= '0;
      fill_rd_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        fill_rd_valid <= fill_valid[in_cls];
      end
      if (cmd.push || cmd.pop) begin
        fill_valid[cls_q] <= 1'b1;
      end
    end
  end

  assign fill_cur = fill_rd_valid ? fill_rd : '0;
  assign fill_m1  = fill_cur - FILL_W'(1);
  assign fill_p1  = fill_cur + FILL_W'(1);

  // Fill memory write
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      fill_mem[cls_q] <= fill_p1;
    end else if (cmd.pop) begin
      fill_mem[cls_q] <= fill_m1;
    end
  end

  // Stack memory, one write or one read per cycle
  assign push_addr = {cls_q, fill_cur[DEPTH_BITS-1:0]};
  assign pop_addr  = {cls_q, fill_m1[DEPTH_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[push_addr] <= addr_q;
    end
    if (cmd.pop) begin
      stack_rd <= stack_mem[pop_addr];
    end
  end

  // Status towards the controller
  always_comb begin
    stat.uncacheable = uncache_q;
    stat.is_put      = (mode_q == MODE_PUT);
    stat.empty       = (fill_cur == '0) || (fill_cur > FILL_W'(STACK_DEPTH));
    stat.full        = (fill_cur >= FILL_W'(STACK_DEPTH));
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status        <= cmd.status;
      found_address <= cmd.found_sel ? stack_rd : '0;
      class_index   <= uncache_q ? CLASS_IDX_W'(NUM_CLASSES) : CLASS_IDX_W'(cls_q);
    end
  end

endmodule

>>> rtl/size_class_block_cache_unit.sv
// ----------------------------------------------------------------------------
// size_class_block_cache_unit
// Free block cache: 64 size classes of 16 bytes, each a LIFO of 16 addresses.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// one result, shown for a single cycle with done high; the result must be
// taken in that cycle as it cannot be held. A put, a get from an empty class
// and an uncacheable size get their result registered from the lookup state;
// a successful get gets it from the pop state after that, as the fill count
// read and then the stack read each use a registered memory port in turn.
// busy drops as the result is registered, so the next request may be accepted
// in the cycle done is high. No clearing pass is needed after reset.
module size_class_block_cache_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode,
  input  logic [scbc_pkg::SIZE_W-1:0]      request_size,
  input  logic [scbc_pkg::ADDR_BITS-1:0]   block_address,
  output logic                             done,
  output logic [scbc_pkg::STATUS_W-1:0]    status,
  output logic [scbc_pkg::ADDR_BITS-1:0]   found_address,
  output logic [scbc_pkg::CLASS_IDX_W-1:0] class_index
);
  import scbc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  scbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Counts, stacks and result registers
  scbc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .request_size  (request_size),
    .block_address (block_address),
    .done          (done),
    .status        (status),
    .found_address (found_address),
    .class_index   (class_index)
  );

endmodule
